// ===== rtl/pse_pkg.sv =====
// shared types and constants of the pcm sample encoder
`timescale 1ns / 1ps

package pse_pkg;

    // widths of the stream fields
    localparam int SAMPLE_W = 16;
    localparam int IN_DATA_W = 2 * SAMPLE_W;
    localparam int OUT_DATA_W = 16;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WIDE_OUTPUT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ENCODING_MODE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DOWNMIX_PAIR = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDE_SOURCE = 2'd3;

    // encoding modes, the unused code behaves as signed
    localparam logic [1:0] ENC_SIGNED = 2'd0;
    localparam logic [1:0] ENC_UNSIGNED = 2'd1;
    localparam logic [1:0] ENC_DELTA = 2'd2;

    // offsets for unsigned output
    localparam logic [SAMPLE_W-1:0] OFFSET_WIDE = 16'h8000;
    localparam logic [SAMPLE_W-1:0] OFFSET_NARROW = 16'h0080;

    // configuration register set
    typedef struct packed {
        logic       wide_output;
        logic [1:0] encoding_mode;
        logic       downmix_pair;
        logic       wide_source;
    } cfg_t;

endpackage

// ===== rtl/pcm_sample_encoder_top.sv =====
// top level of the pcm sample encoder: config registers, input register, stages
`timescale 1ns / 1ps

// PCM sample encoder, one input word gives one output word.
// Slave stream: s_tdata carries sample_a (bits 15:0) and sample_b (31:16),
// s_tuser is first_sample, s_tlast is last_sample.
// Master stream: m_tdata carries out_word (15:0), m_tlast copies last_sample.
// Config: cfg_we writes cfg_data into register cfg_index (0 wide_output,
// 1 encoding_mode, 2 downmix_pair, 3 wide_source) at the clock edge; write
// only while no word is in flight.
// Path: an accepted word goes into the input register, which feeds source
// select, downmix and coding in one pass into the output register behind m_tvalid.
// Throughput is one word per cycle while m_tready is high; the previous-value
// register is updated as each word enters the output register.
// Reset clears config, previous value and both valid flags.
// When m_tready is low the output word holds, the input register still takes
// one more word, and s_tready drops once both registers are full.

module pcm_sample_encoder_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    // config write port
    input  logic                               cfg_we,
    input  logic [pse_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pse_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pse_pkg::IN_DATA_W-1:0]      s_tdata,   // sample_a, sample_b
    input  logic                               s_tuser,   // first_sample
    input  logic                               s_tlast,
    // output stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pse_pkg::OUT_DATA_W-1:0]     m_tdata,   // out_word
    output logic                               m_tlast
);

    pse_pkg::cfg_t                    cfg_reg;
    pse_pkg::cfg_t                    cfg_next;
    logic                             in_valid_reg;
    logic                             in_valid_next;
    logic [pse_pkg::SAMPLE_W-1:0]     sample_a_reg;
    logic [pse_pkg::SAMPLE_W-1:0]     sample_b_reg;
    logic                             first_reg;
    logic                             last_reg;
    logic                             enc_ready;
    logic                             in_load;
    logic [pse_pkg::SAMPLE_W-1:0]     sample;

    // config register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                pse_pkg::REG_WIDE_OUTPUT:   cfg_next.wide_output   = cfg_data[0];
                pse_pkg::REG_ENCODING_MODE: cfg_next.encoding_mode = cfg_data[1:0];
                pse_pkg::REG_DOWNMIX_PAIR:  cfg_next.downmix_pair  = cfg_data[0];
                pse_pkg::REG_WIDE_SOURCE:   cfg_next.wide_source   = cfg_data[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    // input register handshake
    assign s_tready = !in_valid_reg || enc_ready;
    assign in_load  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_load)
        begin
            in_valid_next = 1'b1;
        end
        else if (enc_ready)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg      <= '0;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            in_valid_reg <= in_valid_next;
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            sample_a_reg <= s_tdata[15:0];
            sample_b_reg <= s_tdata[31:16];
            first_reg    <= s_tuser;
            last_reg     <= s_tlast;
        end
    end

    // source select and downmix
    pse_src u_src
    (
        .cfg      (cfg_reg),
        .sample_a (sample_a_reg),
        .sample_b (sample_b_reg),
        .sample   (sample)
    );

    // coding and output register
    pse_enc u_enc
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid_reg),
        .in_ready     (enc_ready),
        .first_sample (first_reg),
        .last_sample  (last_reg),
        .sample       (sample),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_word     (m_tdata),
        .out_last     (m_tlast)
    );

    // an accepted word is held in the input register next cycle
    a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted word not held in input register");

    // back pressure only when both registers are full and the output stalls
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && m_tvalid && !m_tready))
        else $error("input stalled without full pipeline");

    // a pending input word moves on into the output register
    a_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && (!m_tvalid || m_tready)) |=> m_tvalid)
        else $error("pending word did not reach output register");

endmodule

// ===== rtl/pse_src.sv =====
// source byte selection and optional rounded downmix of a sample pair
`timescale 1ns / 1ps

module pse_src
(
    input  pse_pkg::cfg_t                   cfg,
    input  logic [pse_pkg::SAMPLE_W-1:0]    sample_a,
    input  logic [pse_pkg::SAMPLE_W-1:0]    sample_b,
    output logic [pse_pkg::SAMPLE_W-1:0]    sample
);

    logic [pse_pkg::SAMPLE_W-1:0] src_a;
    logic [pse_pkg::SAMPLE_W-1:0] src_b;
    logic [pse_pkg::SAMPLE_W+1:0] pair_sum;

    // full word, high byte or low byte, sign extended
    function automatic logic [pse_pkg::SAMPLE_W-1:0] pick_source(
        input logic [pse_pkg::SAMPLE_W-1:0] raw,
        input logic                         wide_src,
        input logic                         wide_out
    );
        logic [7:0] byte_val;
        begin
            byte_val = wide_src ? raw[15:8] : raw[7:0];
            if (wide_src && wide_out)
            begin
                pick_source = raw;
            end
            else
            begin
                pick_source = {{8{byte_val[7]}}, byte_val};
            end
        end
    endfunction

    assign src_a = pick_source(sample_a, cfg.wide_source, cfg.wide_output);
    assign src_b = pick_source(sample_b, cfg.wide_source, cfg.wide_output);

    // floor((a + b + 1) / 2), result always fits the sample width
    assign pair_sum = {{2{src_a[15]}}, src_a} + {{2{src_b[15]}}, src_b} + 18'd1;

    assign sample = cfg.downmix_pair ? pair_sum[16:1] : src_a;

endmodule

// ===== rtl/pse_enc.sv =====
// encoding stage: previous value, signed/unsigned/delta coding and output register
`timescale 1ns / 1ps

module pse_enc
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  pse_pkg::cfg_t                    cfg,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             first_sample,
    input  logic                             last_sample,
    input  logic [pse_pkg::SAMPLE_W-1:0]     sample,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [pse_pkg::OUT_DATA_W-1:0]   out_word,
    output logic                             out_last
);

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [pse_pkg::OUT_DATA_W-1:0]   out_word_reg;
    logic                             out_last_reg;
    logic [pse_pkg::SAMPLE_W-1:0]     prev_reg;
    logic [pse_pkg::SAMPLE_W-1:0]     prev_next;
    logic [pse_pkg::SAMPLE_W-1:0]     prev_eff;
    logic [pse_pkg::SAMPLE_W-1:0]     coded;
    logic [pse_pkg::OUT_DATA_W-1:0]   word_next;
    logic                             load;

    // output register is free when empty or being taken
    assign in_ready = !out_valid_reg || out_ready;
    assign load = in_valid && in_ready;

    // first word of a pass starts the delta chain from zero
    assign prev_eff = first_sample ? '0 : prev_reg;

    // coding of one sample
    always_comb
    begin
        case (cfg.encoding_mode)
            pse_pkg::ENC_DELTA:
                coded = sample - prev_eff;
            pse_pkg::ENC_UNSIGNED:
                coded = sample + (cfg.wide_output ? pse_pkg::OFFSET_WIDE
                                                  : pse_pkg::OFFSET_NARROW);
            default:
                coded = sample;
        endcase
        word_next = cfg.wide_output ? coded : {8'd0, coded[7:0]};
    end

    // previous value follows the sample in delta mode only, else held or zeroed
    always_comb
    begin
        prev_next = prev_reg;
        if (load)
        begin
            if (cfg.encoding_mode == pse_pkg::ENC_DELTA)
            begin
                prev_next = sample;
            end
            else
            begin
                prev_next = prev_eff;
            end
        end
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            prev_reg      <= prev_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_word_reg <= word_next;
            out_last_reg <= last_sample;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench of the pcm sample encoder: stimulus, encoder model, checker
`timescale 1ns / 1ps

module tb_top;

    // unused encoding code, the block treats it as signed
    localparam logic [1:0] ENC_SPARE = 2'd3;
    localparam int ITEMS_PER_SETTING = 28;
    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        logic        first;
        logic [15:0] a;
        logic [15:0] b;
        logic        last;
    } sample_item_t;

    typedef struct packed {
        logic [15:0] word;
        logic        last;
    } encoded_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [pse_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [pse_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [pse_pkg::IN_DATA_W-1:0]   s_tdata = '0;
    logic                            s_tuser = 1'b0;
    logic                            s_tlast = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [pse_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic                            m_tlast;

    // model copy of the registers and of the delta history
    logic       out_wide = 1'b0;
    logic [1:0] code_mode = pse_pkg::ENC_SIGNED;
    logic       mix_pair = 1'b0;
    logic       src_wide = 1'b0;
    logic [15:0] prev_sample = '0;

    sample_item_t sample_queue[$];
    encoded_t     encoded_queue[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_go = 1'b0;
    logic hold_on = 1'b0;
    int words_sent = 0;
    int words_checked = 0;
    int mismatches = 0;
    int settings_run = 0;

    pcm_sample_encoder_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // sample_a, sample_b
        .s_tuser   (s_tuser),   // first_sample
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // out_word
        .m_tlast   (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // selected source as a signed integer
    function automatic int source_value(logic [15:0] raw);
        logic [7:0] sel8;
        if (src_wide && out_wide)
            return int'($signed(raw));
        sel8 = src_wide ? raw[15:8] : raw[7:0];
        return int'($signed(sel8));
    endfunction

    // encode one sample and advance the delta history
    function automatic encoded_t encode_sample(sample_item_t it);
        int          s;
        logic [15:0] s16;
        logic [15:0] mask;
        encoded_t    r;
        s = source_value(it.a);
        mask = out_wide ? 16'hFFFF : 16'h00FF;
        if (it.first)
            prev_sample = '0;
        if (mix_pair)
            s = (s + source_value(it.b) + 1) >>> 1;
        s16 = 16'(s);
        case (code_mode)
            pse_pkg::ENC_DELTA:
            begin
                r.word = (s16 - prev_sample) & mask;
                prev_sample = s16;
            end
            pse_pkg::ENC_UNSIGNED:
                r.word = (s16 + (out_wide ? pse_pkg::OFFSET_WIDE
                                          : pse_pkg::OFFSET_NARROW)) & mask;
            default:
                r.word = s16 & mask;
        endcase
        r.last = it.last;
        return r;
    endfunction

    // driver: predict on accept, then offer the next word or idle
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                encoded_queue.push_back(encode_sample({s_tuser, s_tdata[15:0],
                                                       s_tdata[31:16], s_tlast}));
                words_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    sample_item_t it;
                    it = sample_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {it.b, it.a};
                    s_tuser <= it.first;
                    s_tlast <= it.last;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
    end

    // long receiver hold-off to fill the block
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    // monitor: compare each output word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (encoded_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: word=%h last=%b", m_tdata, m_tlast);
            end
            else
            begin
                encoded_t exp_w;
                exp_w = encoded_queue.pop_front();
                words_checked++;
                if (m_tdata !== exp_w.word || m_tlast !== exp_w.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word mismatch: expected word=%h last=%b, %s%h last=%b",
                                 exp_w.word, exp_w.last, "got word=", m_tdata, m_tlast);
                end
            end
        end
    end

    // overall time limit
    initial
    begin
        #2000000;
        $display("[pcm_sample_encoder_top] ERROR");
        $finish;
    end

    task automatic write_reg(logic [pse_pkg::CFG_INDEX_W-1:0] idx,
                             logic [pse_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
    endtask

    task automatic apply_config(logic wo, logic [1:0] mode, logic dm, logic ws);
        write_reg(pse_pkg::REG_WIDE_OUTPUT, {1'b0, wo});
        write_reg(pse_pkg::REG_ENCODING_MODE, mode);
        write_reg(pse_pkg::REG_DOWNMIX_PAIR, {1'b0, dm});
        write_reg(pse_pkg::REG_WIDE_SOURCE, {1'b0, ws});
        @(posedge clk);
        cfg_we <= 1'b0;
        out_wide = wo;
        code_mode = mode;
        mix_pair = dm;
        src_wide = ws;
        settings_run++;
    endtask

    task automatic add_item(logic first, logic [15:0] a, logic [15:0] b, logic last);
        sample_queue.push_back({first, a, b, last});
    endtask

    // block is idle once every prediction has come back, plus pipeline slack
    task automatic wait_drained();
        while (sample_queue.size() != 0 || s_tvalid || encoded_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [15:0] random_sample();
        logic [15:0] corners[8];
        corners = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                    16'h007F, 16'h0080, 16'hFF80, 16'h7F00};
        if ($urandom_range(7) == 0)
            return corners[$urandom_range(7)];
        return 16'($urandom);
    endfunction

    // stimulus
    initial
    begin
        int n;
        int len;
        logic broken;
        logic [4:0] combo;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // 16-bit delta, wrap at the extremes and history cleared on a new pass
        apply_config(1'b1, pse_pkg::ENC_DELTA, 1'b0, 1'b1);
        add_item(1'b1, 16'h7FFF, 16'h0000, 1'b0);
        add_item(1'b0, 16'h8000, 16'h0000, 1'b0);
        add_item(1'b0, 16'hFFFF, 16'h0000, 1'b1);
        add_item(1'b1, 16'h0001, 16'hFFFF, 1'b0);
        add_item(1'b0, 16'h1234, 16'h8000, 1'b1);
        wait_drained();

        // 8-bit unsigned downmix of low bytes, floor rounding of negatives
        apply_config(1'b0, pse_pkg::ENC_UNSIGNED, 1'b1, 1'b0);
        add_item(1'b0, 16'h007F, 16'h007F, 1'b0);
        add_item(1'b0, 16'h0080, 16'h0080, 1'b0);
        add_item(1'b0, 16'h0080, 16'h007F, 1'b0);
        add_item(1'b0, 16'hFF7F, 16'h0081, 1'b1);
        add_item(1'b0, 16'h00FF, 16'h0000, 1'b0);
        add_item(1'b0, 16'h00FE, 16'hFF00, 1'b1);
        wait_drained();

        // unused mode code with a full 16-bit downmix
        apply_config(1'b1, ENC_SPARE, 1'b1, 1'b1);
        add_item(1'b0, 16'h7FFF, 16'h7FFF, 1'b0);
        add_item(1'b0, 16'h8000, 16'h8000, 1'b0);
        add_item(1'b0, 16'h8000, 16'h7FFF, 1'b1);
        add_item(1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
        wait_drained();

        // 8-bit delta on high bytes
        apply_config(1'b0, pse_pkg::ENC_DELTA, 1'b0, 1'b1);
        add_item(1'b1, 16'h7F00, 16'h0000, 1'b0);
        add_item(1'b0, 16'h8000, 16'h0000, 1'b0);
        add_item(1'b0, 16'h00FF, 16'h0000, 1'b1);
        wait_drained();

        // random passes over every register setting and idle pattern
        for (int k = 0; k < 32; k++)
        begin
            combo = 5'(k);
            apply_config(combo[0], combo[4:3], combo[1], combo[2]);
            case ((k + k / 8) % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 50;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 50;
                end
                default:
                begin
                    send_idle_pct = 26;
                    recv_stall_pct = 26;
                end
            endcase
            if (k == 5)
            begin
                send_idle_pct = 0;
                hold_go = 1'b1;
            end
            n = 0;
            while (n < ITEMS_PER_SETTING)
            begin
                len = $urandom_range(1, 10);
                broken = ($urandom_range(9) == 0);
                for (int i = 0; i < len && n < ITEMS_PER_SETTING; i++)
                begin
                    if (broken)
                        add_item(1'($urandom_range(1)), random_sample(), random_sample(),
                                 1'($urandom_range(1)));
                    else
                        add_item(i == 0, random_sample(), random_sample(), i == len - 1);
                    n++;
                end
            end
            wait_drained();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (8) @(posedge clk);

        $display("run covered %0d register settings, all idle patterns, a long output hold",
                 settings_run);
        $display("words sent %0d, words checked %0d, mismatches %0d",
                 words_sent, words_checked, mismatches);
        if (mismatches == 0 && encoded_queue.size() == 0)
            $display("[pcm_sample_encoder_top] OK");
        else
            $display("[pcm_sample_encoder_top] ERROR");
        $finish;
    end

endmodule
